[rtl/stdu_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the trap decision unit.
// No dependencies.
package stdu_pkg;

  // mcause codes
  localparam logic [31:0] CauseMtimer  = 32'h8000_0007;
  localparam logic [31:0] CauseEcallS  = 32'd9;
  localparam logic [31:0] CauseIllegal = 32'd2;

  // extension ids (legacy calls are ids 0..2)
  localparam logic [31:0] ExtLegacySetTimer = 32'd0;
  localparam logic [31:0] ExtLegacyPutchar  = 32'd1;
  localparam logic [31:0] ExtLegacyGetchar  = 32'd2;
  localparam logic [31:0] ExtBase           = 32'h0000_0010;
  localparam logic [31:0] ExtTime           = 32'h5449_4D45;
  localparam logic [31:0] ExtSrst           = 32'h5352_5354;

  // BASE function ids
  localparam logic [31:0] FidSpecVersion = 32'd0;
  localparam logic [31:0] FidImplId      = 32'd1;
  localparam logic [31:0] FidImplVersion = 32'd2;
  localparam logic [31:0] FidProbeExt    = 32'd3;
  localparam logic [31:0] FidMachVendor  = 32'd4;
  localparam logic [31:0] FidMachArch    = 32'd5;
  localparam logic [31:0] FidMachImpl    = 32'd6;

  // TIME and SRST function ids
  localparam logic [31:0] FidSetTimer = 32'd0;
  localparam logic [31:0] FidSysReset = 32'd0;

  localparam logic [31:0] SpecVersion    = 32'h0000_0002;
  localparam logic [31:0] ErrUnsupported = 32'hFFFF_FFFE;

  // rdtime / rdtimeh decode
  localparam logic [6:0]  OpcSystem = 7'h73;
  localparam logic [2:0]  Funct3Csrrs = 3'd2;
  localparam logic [11:0] CsrTime   = 12'hC01;
  localparam logic [11:0] CsrTimeh  = 12'hC81;

  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharPanic   = 8'h21;

  localparam logic [3:0] SlotA0 = 4'd4;

  // configuration register indexes
  localparam logic [1:0] CfgFallbackTicks = 2'd0;
  localparam logic [1:0] CfgImplId        = 2'd1;
  localparam logic [1:0] CfgImplRevision  = 2'd2;

  localparam logic [31:0] FallbackTicksRst = 32'd2500000;
  localparam logic [31:0] ImplIdRst        = 32'h4B4F_5449;
  localparam logic [31:0] ImplRevisionRst  = 32'd1;

  typedef enum logic [1:0] {
    RegWrNone   = 2'd0,
    RegWrSingle = 2'd1,
    RegWrPair   = 2'd2
  } reg_write_e;

  typedef enum logic [1:0] {
    TpKeep     = 2'd0,
    TpSetStip  = 2'd1,
    TpClrStip  = 2'd2
  } timer_pend_e;

  typedef struct packed {
    logic [31:0] trap_cause;
    logic [31:0] ext_id;
    logic [31:0] func_id;
    logic [31:0] arg_zero;
    logic [31:0] arg_one;
    logic [31:0] trap_word;
    logic [63:0] time_now;
    logic [8:0]  key_code;
  } trap_req_t;

  typedef struct packed {
    reg_write_e  reg_write;
    logic [3:0]  reg_slot;
    logic [31:0] reg_value;
    logic [31:0] second_value;
    logic        pc_advance;
    logic        compare_write;
    logic [63:0] compare_value;
    timer_pend_e timer_pending;
    logic        char_valid;
    logic [7:0]  char_out;
    logic        halt;
    logic        key_pop;
  } trap_rsp_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
  } frame_slot_t;

  // Caller-saved integer register -> trap frame slot.
  function automatic frame_slot_t frame_slot_of(logic [4:0] rd);
    frame_slot_t fs;
    fs.hit  = 1'b1;
    fs.slot = 4'd0;
    if (rd == 5'd1) begin
      fs.slot = 4'd0;
    end else if (rd >= 5'd5 && rd <= 5'd7) begin
      fs.slot = 4'(rd - 5'd4);
    end else if (rd >= 5'd10 && rd <= 5'd17) begin
      fs.slot = 4'(rd - 5'd6);
    end else if (rd >= 5'd28) begin
      fs.slot = 4'(rd - 5'd16);
    end else begin
      fs.hit = 1'b0;
    end
    return fs;
  endfunction

endpackage

[rtl/sbi_trap_decision_unit.sv]
`timescale 1ns / 1ps
// Trap decision unit: request register, decode logic, response register.
// Depends on stdu_pkg.
//
// The request register loads at the accepting edge and the response register
//   loads from it once it can take. Throughput: one request per cycle as long
//   as responses are taken; the only logic between the two registers is the
//   decode and the 64-bit compare add.
// Reset: rst_ni clears both valid flags and loads the configuration registers
//   with fallback 2500000, implementation id 0x4B4F5449 and revision 1.
module sbi_trap_decision_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [31:0]              cfg_data_i,
  // request channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [31:0]              trap_cause_i,
  input  logic [31:0]              ext_id_i,
  input  logic [31:0]              func_id_i,
  input  logic [31:0]              arg_zero_i,
  input  logic [31:0]              arg_one_i,
  input  logic [31:0]              trap_word_i,
  input  logic [63:0]              time_now_i,
  input  logic signed [8:0]        key_code_i,
  // response channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output stdu_pkg::reg_write_e     reg_write_o,
  output logic [3:0]               reg_slot_o,
  output logic [31:0]              reg_value_o,
  output logic [31:0]              second_value_o,
  output logic                     pc_advance_o,
  output logic                     compare_write_o,
  output logic [63:0]              compare_value_o,
  output stdu_pkg::timer_pend_e    timer_pending_o,
  output logic                     char_valid_o,
  output logic [7:0]               char_out_o,
  output logic                     halt_o,
  output logic                     key_pop_o
);
  import stdu_pkg::*;

  // configuration
  logic [31:0] fallback_ticks_q, impl_id_q, impl_rev_q;

  // pipeline registers
  logic      req_valid_q, rsp_valid_q;
  trap_req_t req_q;
  trap_rsp_t rsp_q, rsp_d;

  logic rsp_take;   // response register can load this cycle
  logic req_take;   // request register can load this cycle

  // Response stage loads when empty or being drained; request stage
  // loads when empty or when its content moves on. This lets a new
  // request in while a finished response is still waiting.
  assign rsp_take   = !rsp_valid_q || out_ready_i;
  assign req_take   = !req_valid_q || rsp_take;
  assign in_ready_o = req_take;

  // config writes: indexes beyond the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_ticks_q <= FallbackTicksRst;
      impl_id_q        <= ImplIdRst;
      impl_rev_q       <= ImplRevisionRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFallbackTicks: fallback_ticks_q <= cfg_data_i;
        CfgImplId:        impl_id_q        <= cfg_data_i;
        CfgImplRevision:  impl_rev_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_take) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take && in_valid_i) begin
      req_q.trap_cause <= trap_cause_i;
      req_q.ext_id     <= ext_id_i;
      req_q.func_id    <= func_id_i;
      req_q.arg_zero   <= arg_zero_i;
      req_q.arg_one    <= arg_one_i;
      req_q.trap_word  <= trap_word_i;
      req_q.time_now   <= time_now_i;
      req_q.key_code   <= key_code_i;
    end
  end

  // ------------------------------------------------------------------
  // Decode
  // ------------------------------------------------------------------
  logic [11:0] csr_num;
  frame_slot_t rd_slot;
  logic        is_rdtime;
  logic        key_none;
  logic [31:0] key_ext;
  logic        probe_hit;

  assign csr_num  = req_q.trap_word[31:20];
  assign rd_slot  = frame_slot_of(req_q.trap_word[11:7]);
  assign is_rdtime = (req_q.trap_word[6:0] == OpcSystem)
                  && (req_q.trap_word[14:12] == Funct3Csrrs)
                  && (req_q.trap_word[19:15] == 5'd0)
                  && rd_slot.hit
                  && ((csr_num == CsrTime) || (csr_num == CsrTimeh));
  assign key_none = req_q.key_code[8];
  assign key_ext  = {{23{req_q.key_code[8]}}, req_q.key_code};
  assign probe_hit = (req_q.arg_zero == ExtBase) || (req_q.arg_zero == ExtTime)
                  || (req_q.arg_zero == ExtSrst) || (req_q.arg_zero <= 32'd2);

  always_comb begin
    logic [31:0] err;
    logic [31:0] res;
    logic        pair;
    logic        panic;

    err   = '0;
    res   = '0;
    pair  = 1'b0;
    panic = 1'b0;

    rsp_d.reg_write     = RegWrNone;
    rsp_d.reg_slot      = '0;
    rsp_d.reg_value     = '0;
    rsp_d.second_value  = '0;
    rsp_d.pc_advance    = 1'b0;
    rsp_d.compare_write = 1'b0;
    rsp_d.compare_value = '0;
    rsp_d.timer_pending = TpKeep;
    rsp_d.char_valid    = 1'b0;
    rsp_d.char_out      = '0;
    rsp_d.halt          = 1'b0;
    rsp_d.key_pop       = 1'b0;

    if (req_q.trap_cause == CauseMtimer) begin
      // inject STIP, rearm a fallback period ahead (wraps mod 2^64)
      rsp_d.timer_pending = TpSetStip;
      rsp_d.compare_write = 1'b1;
      rsp_d.compare_value = req_q.time_now + {32'd0, fallback_ticks_q};
    end else if (req_q.trap_cause == CauseEcallS) begin
      rsp_d.pc_advance = 1'b1;
      pair = 1'b1;
      if (req_q.ext_id == ExtLegacySetTimer) begin
        pair = 1'b0;
        rsp_d.compare_write = 1'b1;
        rsp_d.timer_pending = TpClrStip;
        rsp_d.compare_value = {req_q.arg_one, req_q.arg_zero};
        rsp_d.reg_write     = RegWrSingle;
        rsp_d.reg_slot      = SlotA0;
      end else if (req_q.ext_id == ExtLegacyPutchar) begin
        pair = 1'b0;
        rsp_d.char_valid = 1'b1;
        rsp_d.char_out   = req_q.arg_zero[7:0];
        rsp_d.reg_write  = RegWrSingle;
        rsp_d.reg_slot   = SlotA0;
      end else if (req_q.ext_id == ExtLegacyGetchar) begin
        // negative code: nothing ready, written as is but not popped
        pair = 1'b0;
        rsp_d.reg_write = RegWrSingle;
        rsp_d.reg_slot  = SlotA0;
        rsp_d.reg_value = key_ext;
        rsp_d.key_pop   = !key_none;
      end else if (req_q.ext_id == ExtBase) begin
        case (req_q.func_id)
          FidSpecVersion: res = SpecVersion;
          FidImplId:      res = impl_id_q;
          FidImplVersion: res = impl_rev_q;
          FidProbeExt:    res = {31'd0, probe_hit};
          FidMachVendor, FidMachArch, FidMachImpl: res = '0;
          default:        err = ErrUnsupported;
        endcase
      end else if (req_q.ext_id == ExtTime) begin
        if (req_q.func_id == FidSetTimer) begin
          rsp_d.compare_write = 1'b1;
          rsp_d.timer_pending = TpClrStip;
          rsp_d.compare_value = {req_q.arg_one, req_q.arg_zero};
        end else begin
          err = ErrUnsupported;
        end
      end else if (req_q.ext_id == ExtSrst) begin
        if (req_q.func_id == FidSysReset) begin
          // system reset: newline then halt, frame untouched
          pair = 1'b0;
          rsp_d.pc_advance = 1'b0;
          rsp_d.char_valid = 1'b1;
          rsp_d.char_out   = CharNewline;
          rsp_d.halt       = 1'b1;
        end else begin
          err = ErrUnsupported;
        end
      end else begin
        err = ErrUnsupported;
      end
      if (pair) begin
        rsp_d.reg_write    = RegWrPair;
        rsp_d.reg_slot     = SlotA0;
        rsp_d.reg_value    = err;
        rsp_d.second_value = res;
      end
    end else if (req_q.trap_cause == CauseIllegal) begin
      // rdtime / rdtimeh emulation into a caller-saved rd
      if (is_rdtime) begin
        rsp_d.reg_write  = RegWrSingle;
        rsp_d.reg_slot   = rd_slot.slot;
        rsp_d.pc_advance = 1'b1;
        rsp_d.reg_value  = (csr_num == CsrTime) ? req_q.time_now[31:0]
                                                : req_q.time_now[63:32];
      end else begin
        panic = 1'b1;
      end
    end else begin
      panic = 1'b1;
    end

    if (panic) begin
      rsp_d.char_valid = 1'b1;
      rsp_d.char_out   = CharPanic;
      rsp_d.halt       = 1'b1;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_take) begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_take && req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o     = rsp_valid_q;
  assign reg_write_o     = rsp_q.reg_write;
  assign reg_slot_o      = rsp_q.reg_slot;
  assign reg_value_o     = rsp_q.reg_value;
  assign second_value_o  = rsp_q.second_value;
  assign pc_advance_o    = rsp_q.pc_advance;
  assign compare_write_o = rsp_q.compare_write;
  assign compare_value_o = rsp_q.compare_value;
  assign timer_pending_o = rsp_q.timer_pending;
  assign char_valid_o    = rsp_q.char_valid;
  assign char_out_o      = rsp_q.char_out;
  assign halt_o          = rsp_q.halt;
  assign key_pop_o       = rsp_q.key_pop;

endmodule

[tb/sv/trap_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the trap decision unit: predicts the handler actions for
// every accepted trap request and checks the responses in order.
// Depends on stdu_pkg.
package trap_scoreboard_pkg;
  import stdu_pkg::*;

  class trap_scoreboard;
    logic [31:0] fallback_ticks;
    logic [31:0] impl_id;
    logic [31:0] impl_rev;
    trap_rsp_t   expected_actions[$];
    int          fail_count;
    int          rsp_count;

    function new();
      fallback_ticks = FallbackTicksRst;
      impl_id        = ImplIdRst;
      impl_rev       = ImplRevisionRst;
      fail_count     = 0;
      rsp_count      = 0;
    endfunction

    function void set_registers(logic [31:0] ticks, logic [31:0] id, logic [31:0] rev);
      fallback_ticks = ticks;
      impl_id        = id;
      impl_rev       = rev;
    endfunction

    function int outstanding();
      return expected_actions.size();
    endfunction

    // Handler actions for one trap under the current register values.
    function trap_rsp_t decide_trap(trap_req_t r);
      trap_rsp_t   a;
      logic [31:0] err;
      logic [31:0] res;
      logic        pair;
      logic        panic;
      logic        saved;
      logic [4:0]  rd;
      logic [11:0] csr;
      logic [3:0]  slot;
      a     = '0;
      err   = '0;
      res   = '0;
      pair  = 1'b0;
      panic = 1'b0;
      saved = 1'b1;
      slot  = 4'd0;
      rd    = r.trap_word[11:7];
      csr   = r.trap_word[31:20];
      // caller-saved registers: ra, t0-t2, a0-a7, t3-t6
      case (rd)
        5'd1: slot = 4'd0;
        5'd5, 5'd6, 5'd7: slot = rd[3:0] - 4'd4;
        5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17: slot = rd[3:0] - 4'd6;
        5'd28, 5'd29, 5'd30, 5'd31: slot = rd[3:0];
        default: saved = 1'b0;
      endcase

      if (r.trap_cause == CauseMtimer) begin
        a.timer_pending = TpSetStip;
        a.compare_write = 1'b1;
        a.compare_value = r.time_now + {32'd0, fallback_ticks};
      end else if (r.trap_cause == CauseEcallS) begin
        a.pc_advance = 1'b1;
        pair         = 1'b1;
        case (r.ext_id)
          ExtLegacySetTimer: begin
            pair            = 1'b0;
            a.compare_write = 1'b1;
            a.timer_pending = TpClrStip;
            a.compare_value = {r.arg_one, r.arg_zero};
          end
          ExtLegacyPutchar: begin
            pair         = 1'b0;
            a.char_valid = 1'b1;
            a.char_out   = r.arg_zero[7:0];
          end
          ExtLegacyGetchar: begin
            pair        = 1'b0;
            a.reg_value = {{23{r.key_code[8]}}, r.key_code};
            a.key_pop   = ~r.key_code[8];
          end
          ExtBase: begin
            case (r.func_id)
              FidSpecVersion: res = SpecVersion;
              FidImplId:      res = impl_id;
              FidImplVersion: res = impl_rev;
              FidProbeExt: begin
                res = (r.arg_zero == ExtBase || r.arg_zero == ExtTime ||
                       r.arg_zero == ExtSrst || r.arg_zero <= ExtLegacyGetchar) ? 32'd1 : 32'd0;
              end
              FidMachVendor, FidMachArch, FidMachImpl: res = '0;
              default: err = ErrUnsupported;
            endcase
          end
          ExtTime: begin
            if (r.func_id == FidSetTimer) begin
              a.compare_write = 1'b1;
              a.timer_pending = TpClrStip;
              a.compare_value = {r.arg_one, r.arg_zero};
            end else begin
              err = ErrUnsupported;
            end
          end
          ExtSrst: begin
            if (r.func_id == FidSysReset) begin
              pair         = 1'b0;
              a.pc_advance = 1'b0;
              a.char_valid = 1'b1;
              a.char_out   = CharNewline;
              a.halt       = 1'b1;
            end else begin
              err = ErrUnsupported;
            end
          end
          default: err = ErrUnsupported;
        endcase
        if (r.ext_id <= ExtLegacyGetchar) begin
          a.reg_write = RegWrSingle;
          a.reg_slot  = SlotA0;
        end
        if (pair) begin
          a.reg_write    = RegWrPair;
          a.reg_slot     = SlotA0;
          a.reg_value    = err;
          a.second_value = res;
        end
      end else if (r.trap_cause == CauseIllegal) begin
        if (r.trap_word[6:0] == OpcSystem && r.trap_word[14:12] == Funct3Csrrs &&
            r.trap_word[19:15] == 5'd0 && saved && (csr == CsrTime || csr == CsrTimeh)) begin
          a.reg_write  = RegWrSingle;
          a.reg_slot   = slot;
          a.pc_advance = 1'b1;
          a.reg_value  = (csr == CsrTime) ? r.time_now[31:0] : r.time_now[63:32];
        end else begin
          panic = 1'b1;
        end
      end else begin
        panic = 1'b1;
      end

      if (panic) begin
        a.char_valid = 1'b1;
        a.char_out   = CharPanic;
        a.halt       = 1'b1;
      end
      return a;
    endfunction

    function void note_request(trap_req_t r);
      expected_actions.push_back(decide_trap(r));
    endfunction

    function void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen)
        note_failure($sformatf("response %0d %s: expected %0h, got %0h",
                               rsp_count, name, want, seen));
    endfunction

    function void check_response(trap_rsp_t got);
      trap_rsp_t want;
      rsp_count++;
      if (expected_actions.size() == 0) begin
        note_failure($sformatf("response %0d arrived with no request outstanding", rsp_count));
        return;
      end
      want = expected_actions.pop_front();
      compare_field("reg_write", want.reg_write, got.reg_write);
      compare_field("reg_slot", want.reg_slot, got.reg_slot);
      compare_field("reg_value", want.reg_value, got.reg_value);
      compare_field("second_value", want.second_value, got.second_value);
      compare_field("pc_advance", want.pc_advance, got.pc_advance);
      compare_field("compare_write", want.compare_write, got.compare_write);
      compare_field("compare_value", want.compare_value, got.compare_value);
      compare_field("timer_pending", want.timer_pending, got.timer_pending);
      compare_field("char_valid", want.char_valid, got.char_valid);
      compare_field("char_out", want.char_out, got.char_out);
      compare_field("halt", want.halt, got.halt);
      compare_field("key_pop", want.key_pop, got.key_pop);
    endfunction
  endclass

endpackage

[tb/sv/tb_sbi_trap_decision_unit.sv]
`timescale 1ns / 1ps
// Top-level testbench for sbi_trap_decision_unit: directed and random trap
// requests with random idling on both channels, checked by the scoreboard.
// Depends on stdu_pkg, trap_scoreboard_pkg and the RTL.
module tb_sbi_trap_decision_unit;
  import stdu_pkg::*;
  import trap_scoreboard_pkg::*;

  // ---------------------------------------------------------------------
  // Signals. Every input is known from time zero.
  // ---------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni         = 1'b0;
  logic              cfg_we_i       = 1'b0;
  logic [1:0]        cfg_index_i    = CfgFallbackTicks;
  logic [31:0]       cfg_data_i     = '0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [31:0]       trap_cause_i   = '0;
  logic [31:0]       ext_id_i       = '0;
  logic [31:0]       func_id_i      = '0;
  logic [31:0]       arg_zero_i     = '0;
  logic [31:0]       arg_one_i      = '0;
  logic [31:0]       trap_word_i    = '0;
  logic [63:0]       time_now_i     = '0;
  logic signed [8:0] key_code_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  reg_write_e        reg_write_o;
  logic [3:0]        reg_slot_o;
  logic [31:0]       reg_value_o;
  logic [31:0]       second_value_o;
  logic              pc_advance_o;
  logic              compare_write_o;
  logic [63:0]       compare_value_o;
  timer_pend_e       timer_pending_o;
  logic              char_valid_o;
  logic [7:0]        char_out_o;
  logic              halt_o;
  logic              key_pop_o;

  trap_scoreboard sb = new();

  // Set by the stimulus; the response side then holds ready low for a long
  // stretch so the pipeline fills and backpressures the request side.
  bit hold_off_req = 1'b0;
  int send_quiet   = 0;

  sbi_trap_decision_unit dut (.*);

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: the slowest legal run is well under a millisecond.
  initial begin
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Idle-cycle draw shared by both sides: mostly a uniform random gap, with
  // occasional bursts of back-to-back traffic.
  // ---------------------------------------------------------------------
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic trap_req_t make_trap(logic [31:0] cause, logic [31:0] eid,
                                          logic [31:0] fid, logic [31:0] a0,
                                          logic [31:0] a1, logic [31:0] word,
                                          logic [63:0] now, logic [8:0] key);
    trap_req_t r;
    r.trap_cause = cause;
    r.ext_id     = eid;
    r.func_id    = fid;
    r.arg_zero   = a0;
    r.arg_one    = a1;
    r.trap_word  = word;
    r.time_now   = now;
    r.key_code   = key;
    return r;
  endfunction

  // Random trap: every field starts fully random, then the cause and the
  // fields it looks at are steered toward the interesting decodes.
  function automatic trap_req_t random_trap();
    trap_req_t r;
    int        roll;
    int        flip;
    r.trap_cause = $urandom;
    r.ext_id     = $urandom;
    r.func_id    = $urandom;
    r.arg_zero   = $urandom;
    r.arg_one    = $urandom;
    r.trap_word  = $urandom;
    r.time_now   = {$urandom, $urandom};
    r.key_code   = 9'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      r.trap_cause = CauseMtimer;
      // push time near the top so the rearm add wraps now and then
      if ($urandom_range(0, 3) == 0) r.time_now[63:32] = 32'hFFFF_FFFF;
    end else if (roll < 62) begin
      r.trap_cause = CauseEcallS;
      case ($urandom_range(0, 7))
        0: r.ext_id = ExtLegacySetTimer;
        1: r.ext_id = ExtLegacyPutchar;
        2: r.ext_id = ExtLegacyGetchar;
        3, 4: r.ext_id = ExtBase;
        5: r.ext_id = ExtTime;
        6: r.ext_id = ExtSrst;
        default: ;  // unknown extension
      endcase
      if ($urandom_range(0, 4) != 0) r.func_id = $urandom_range(0, 7);
      // probe targets
      case ($urandom_range(0, 5))
        0: r.arg_zero = ExtBase;
        1: r.arg_zero = ExtTime;
        2: r.arg_zero = ExtSrst;
        3: r.arg_zero = $urandom_range(0, 3);
        default: ;
      endcase
    end else if (roll < 90) begin
      r.trap_cause = CauseIllegal;
      if ($urandom_range(0, 5) != 0) begin
        // well-formed rdtime/rdtimeh with any rd; sometimes one bit broken
        r.trap_word = {($urandom_range(0, 1) ? CsrTime : CsrTimeh), 5'd0, Funct3Csrrs,
                       5'($urandom), OpcSystem};
        if ($urandom_range(0, 4) == 0) begin
          flip = $urandom_range(0, 31);
          r.trap_word[flip] = ~r.trap_word[flip];
        end
      end
    end else if (roll < 96) begin
      r.trap_cause     = $urandom_range(0, 15);
      r.trap_cause[31] = 1'($urandom);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Request side. Valid goes high (after the idle gap) and stays high with
  // a fixed payload until the request is accepted.
  // ---------------------------------------------------------------------
  task automatic drive_request(input trap_req_t r, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    trap_cause_i <= r.trap_cause;
    ext_id_i     <= r.ext_id;
    func_id_i    <= r.func_id;
    arg_zero_i   <= r.arg_zero;
    arg_one_i    <= r.arg_one;
    trap_word_i  <= r.trap_word;
    time_now_i   <= r.time_now;
    key_code_i   <= r.key_code;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
  endtask

  // Stop offering requests and wait for every response to come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    // two-stage pipeline; waiting on after the queue empties catches a stray response
    repeat (4) @(posedge clk_i);
  endtask

  // All three registers, one per cycle, write enable held across them.
  task automatic write_config(input logic [31:0] ticks, input logic [31:0] id,
                              input logic [31:0] rev);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgFallbackTicks;
    cfg_data_i  <= ticks;
    @(posedge clk_i);
    cfg_index_i <= CfgImplId;
    cfg_data_i  <= id;
    @(posedge clk_i);
    cfg_index_i <= CfgImplRevision;
    cfg_data_i  <= rev;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_registers(ticks, id, rev);
  endtask

  // hold_at: request index at which the long response hold-off is asked.
  // pause_at: request index before which the request side drains.
  task automatic send_random(input int count, input int hold_at, input int pause_at);
    int gap;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_off_req = 1'b1;
      if (i == pause_at) drain();
      gap = draw_wait(send_quiet);
      drive_request(random_trap(), gap);
    end
  endtask

  // ---------------------------------------------------------------------
  // Response side: random stall before each response, then ready stays
  // high until one is taken and checked.
  // ---------------------------------------------------------------------
  initial begin : response_sink
    int        stall;
    int        quiet;
    trap_rsp_t got;
    quiet = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        stall        = 400;
        hold_off_req = 1'b0;
      end else begin
        stall = draw_wait(quiet);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.reg_write     = reg_write_o;
      got.reg_slot      = reg_slot_o;
      got.reg_value     = reg_value_o;
      got.second_value  = second_value_o;
      got.pc_advance    = pc_advance_o;
      got.compare_write = compare_write_o;
      got.compare_value = compare_value_o;
      got.timer_pending = timer_pending_o;
      got.char_valid    = char_valid_o;
      got.char_out      = char_out_o;
      got.halt          = halt_o;
      got.key_pop       = key_pop_o;
      sb.check_response(got);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    trap_req_t directed[$];
    int        gap;
    logic [31:0] rdtime_ra;
    logic [31:0] rdtimeh_t6;
    logic [31:0] rdtime_sp;
    rdtime_ra  = {CsrTime, 5'd0, Funct3Csrrs, 5'd1, OpcSystem};
    rdtimeh_t6 = {CsrTimeh, 5'd0, Funct3Csrrs, 5'd31, OpcSystem};
    rdtime_sp  = {CsrTime, 5'd0, Funct3Csrrs, 5'd2, OpcSystem};  // sp is not in the frame

    // timer: rearm wraps past 2^64, then time zero with all other fields high
    directed.push_back(make_trap(CauseMtimer, '0, '0, '0, '0, '0, '1, 9'h000));
    directed.push_back(make_trap(CauseMtimer, '1, '1, '1, '1, '1, '0, 9'h1FF));
    // legacy calls
    directed.push_back(make_trap(CauseEcallS, ExtLegacySetTimer, '0, '1, '1, '0, '0, '0));
    directed.push_back(make_trap(CauseEcallS, ExtLegacyPutchar, '0, 32'hFFFF_FF41, '0, '0,
                                 '0, '0));
    // getchar: nothing ready, out-of-range negative, largest and smallest key
    directed.push_back(make_trap(CauseEcallS, ExtLegacyGetchar, '0, '0, '0, '0, '0, 9'h1FF));
    directed.push_back(make_trap(CauseEcallS, ExtLegacyGetchar, '0, '0, '0, '0, '0, 9'h100));
    directed.push_back(make_trap(CauseEcallS, ExtLegacyGetchar, '0, '0, '0, '0, '0, 9'h0FF));
    directed.push_back(make_trap(CauseEcallS, ExtLegacyGetchar, '1, '1, '1, '1, '1, 9'h000));
    // BASE functions, probe hit and miss, unknown function ids
    directed.push_back(make_trap(CauseEcallS, ExtBase, FidSpecVersion, '0, '0, '0, '0, '0));
    directed.push_back(make_trap(CauseEcallS, ExtBase, FidImplId, '0, '0, '0, '0, '0));
    directed.push_back(make_trap(CauseEcallS, ExtBase, FidImplVersion, '0, '0, '0, '0, '0));
    directed.push_back(make_trap(CauseEcallS, ExtBase, FidProbeExt, ExtSrst, '0, '0, '0, '0));
    directed.push_back(make_trap(CauseEcallS, ExtBase, FidProbeExt, 32'd3, '0, '0, '0, '0));
    directed.push_back(make_trap(CauseEcallS, ExtBase, FidMachVendor, '0, '0, '0, '0, '0));
    directed.push_back(make_trap(CauseEcallS, ExtBase, FidMachImpl + 32'd1, '0, '0, '0,
                                 '0, '0));
    directed.push_back(make_trap(CauseEcallS, ExtBase, '1, '0, '0, '0, '0, '0));
    // TIME timer set and an unsupported TIME function
    directed.push_back(make_trap(CauseEcallS, ExtTime, FidSetTimer, 32'h0000_1234, '1, '0,
                                 '0, '0));
    directed.push_back(make_trap(CauseEcallS, ExtTime, FidSetTimer + 32'd1, '0, '0, '0,
                                 '0, '0));
    // SRST: reset halts, anything else is unsupported
    directed.push_back(make_trap(CauseEcallS, ExtSrst, FidSysReset, '0, '0, '0, '0, '0));
    directed.push_back(make_trap(CauseEcallS, ExtSrst, FidSysReset + 32'd1, '0, '0, '0,
                                 '0, '0));
    directed.push_back(make_trap(CauseEcallS, '1, '0, '0, '0, '0, '0, '0));
    // rdtime into ra, rdtimeh into t6, rdtime into sp (panics)
    directed.push_back(make_trap(CauseIllegal, '0, '0, '0, '0, rdtime_ra,
                                 64'h0123_4567_89AB_CDEF, '0));
    directed.push_back(make_trap(CauseIllegal, '0, '0, '0, '0, rdtimeh_t6,
                                 64'hFEDC_BA98_7654_3210, '0));
    directed.push_back(make_trap(CauseIllegal, '0, '0, '0, '0, rdtime_sp, '1, '0));
    // any other cause panics
    directed.push_back(make_trap('1, '0, '0, '0, '0, '0, '0, '0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values
    foreach (directed[k]) begin
      gap = draw_wait(send_quiet);
      drive_request(directed[k], gap);
    end
    send_random(350, -1, -1);

    // smallest values; long response hold-off early on
    drain();
    write_config(32'd1, 32'd0, 32'd0);
    send_random(350, 40, -1);

    // largest values; request side pauses until everything is back
    drain();
    write_config('1, '1, '1);
    send_random(350, -1, 175);

    // small random fallback, second hold-off
    drain();
    write_config($urandom_range(1, 1000), $urandom, $urandom);
    send_random(350, 200, -1);

    // large random fallback, second pause
    drain();
    write_config($urandom_range(32'h8000_0000, 32'hFFFF_FFFF), $urandom, $urandom);
    send_random(350, -1, 100);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
